// File: rtl/core/assert_macros.svh
// Assertion macros shared by the bridge forwarder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define LBF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define LBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lbf_pkg.sv
// Shared constants and helpers of the learning bridge forwarder.
`default_nettype none

package lbf_pkg;

    localparam int PORT_W            = 4;
    localparam int ADDR_W            = 48;
    localparam int MASK_W            = 16;
    localparam int DEFAULT_NUM_PORTS = 16;

    // event kinds
    localparam logic [1:0] KIND_FRAME      = 2'd0;
    localparam logic [1:0] KIND_CONNECT    = 2'd1;
    localparam logic [1:0] KIND_DISCONNECT = 2'd2;

    localparam logic [7:0] OCTET_ALL_ONES = 8'hff;

    // broadcast: every octet of the address is all ones
    function automatic logic is_broadcast(input logic [ADDR_W-1:0] addr);
        logic all_ones;
        all_ones = 1'b1;
        for (int i = 0; i < ADDR_W / 8; i++)
        begin
            if (addr[8*i +: 8] != OCTET_ALL_ONES)
                all_ones = 1'b0;
        end
        return all_ones;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/lbf_evt_if.sv
// Event channel: frame headers and port connect/disconnect words.
`default_nettype none

interface lbf_evt_if;
    import lbf_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] dest_addr;
    logic [ADDR_W-1:0] source_addr;

    modport source (output valid, kind, port, dest_addr, source_addr, input ready);
    modport sink   (input valid, kind, port, dest_addr, source_addr, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lbf_dec_if.sv
// Decision channel: egress mask and flood flag, one word per event.
`default_nettype none

interface lbf_dec_if;
    import lbf_pkg::*;

    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] egress_mask;
    logic              flooded;

    modport source (output valid, egress_mask, flooded, input ready);
    modport sink   (input valid, egress_mask, flooded, output ready);
endinterface

`default_nettype wire

// File: rtl/core/learning_bridge_forwarder.sv
// Top level of the learning bridge forwarder.
// One learned station address per port, held in a synchronous memory with one read and one write port.
// A frame header from a connected port is handled by one sweep through that memory,
// one entry per cycle over its single read port: each entry is read, the source
// address is learned on the arrival port and removed from the others, the updated
// entry is written back and compared with the destination. A frame from a connected
// port is not followed by another event until its sweep ends and its decision word is
// loaded; connect and disconnect events, dropped frames and ignored events need no sweep.
// A broadcast, zero or unknown destination floods to all connected ports but the
// arrival port; a destination learned on the arrival port is filtered. The decision
// word sits in an output register and the next event is taken as it leaves.
// After reset every port is closed and unlearned; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module learning_bridge_forwarder #(
    parameter int NUM_PORTS = lbf_pkg::DEFAULT_NUM_PORTS
) (
    input wire logic   clk,
    input wire logic   rst_n,
    lbf_evt_if.sink    evt,
    lbf_dec_if.source  dec
);
    import lbf_pkg::*;

    localparam int IDX_W = $clog2(NUM_PORTS);
    localparam int CNT_W = $clog2(NUM_PORTS + 1);
    localparam int EXT_W = (CNT_W > PORT_W) ? CNT_W : PORT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PORTS - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]           state_reg;
    logic [CNT_W-1:0]     issue_reg;
    logic                 proc_valid_reg;
    logic [IDX_W-1:0]     proc_idx_reg;
    logic [NUM_PORTS-1:0] connected_reg;
    logic                 hit_found_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic [IDX_W-1:0]     sp_reg;
    logic [ADDR_W-1:0]    src_reg;
    logic [ADDR_W-1:0]    dst_reg;
    logic                 lookup_reg;
    logic                 res_valid_reg;
    logic [MASK_W-1:0]    res_mask_reg;
    logic                 res_flood_reg;

    logic [EXT_W-1:0]  port_ext;
    logic              port_ok;
    logic [IDX_W-1:0]  port_idx;
    logic              accept;
    logic              slot_free;
    logic              frame_go;
    logic              ctl_go;
    logic              finish_load;
    logic [ADDR_W-1:0] rdata;
    logic [ADDR_W-1:0] proc_val;
    logic              proc_hit;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0] mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic [MASK_W-1:0] mask;

    // event decode
    assign port_ext  = EXT_W'(evt.port);
    assign port_ok   = port_ext < EXT_W'(NUM_PORTS);
    assign port_idx  = port_ext[IDX_W-1:0];
    assign slot_free = !res_valid_reg || dec.ready;
    assign evt.ready = (state_reg == ST_IDLE) && slot_free;
    assign accept    = evt.valid && evt.ready;
    assign frame_go  = (evt.kind == KIND_FRAME) && port_ok && connected_reg[port_idx];
    assign ctl_go    = port_ok && ((evt.kind == KIND_CONNECT) ||
                                   (evt.kind == KIND_DISCONNECT));
    assign finish_load = (state_reg == ST_FINISH) && slot_free;

    // sweep stage: learn on the arrival port, unlearn elsewhere, then compare
    always_comb
    begin
        if (proc_idx_reg == sp_reg)
            proc_val = src_reg;
        else if ((src_reg != '0) && (rdata == src_reg))
            proc_val = '0;
        else
            proc_val = rdata;
    end
    assign proc_hit = proc_valid_reg && lookup_reg && connected_reg[proc_idx_reg] &&
                      (proc_val == dst_reg);

    // memory port steering
    assign mem_re    = (state_reg == ST_SWEEP) && (issue_reg < CNT_W'(NUM_PORTS));
    assign mem_raddr = issue_reg[IDX_W-1:0];
    assign mem_we    = proc_valid_reg || (accept && ctl_go);
    assign mem_waddr = proc_valid_reg ? proc_idx_reg : port_idx;
    assign mem_wdata = proc_valid_reg ? proc_val : '0;

    lbf_addr_mem #(
        .NUM_PORTS (NUM_PORTS)
    ) u_addr_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rdata)
    );

    lbf_mask_gen #(
        .NUM_PORTS (NUM_PORTS)
    ) u_mask_gen (
        .connected   (connected_reg),
        .src_port    (sp_reg),
        .hit_found   (hit_found_reg),
        .hit_port    (hit_idx_reg),
        .egress_mask (mask)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_reg      <= '0;
            proc_valid_reg <= 1'b0;
            connected_reg  <= '0;
            hit_found_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            proc_valid_reg <= mem_re;
            if (mem_re)
                issue_reg <= issue_reg + CNT_W'(1);
            if (proc_hit && !hit_found_reg)
                hit_found_reg <= 1'b1;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (ctl_go)
                            connected_reg[port_idx] <= (evt.kind == KIND_CONNECT);
                        if (frame_go)
                        begin
                            state_reg     <= ST_SWEEP;
                            issue_reg     <= '0;
                            hit_found_reg <= 1'b0;
                        end
                    end
                end
                ST_SWEEP:
                begin
                    if (proc_valid_reg && (proc_idx_reg == LAST_IDX))
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (slot_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // output word register
            if ((accept && !frame_go) || finish_load)
                res_valid_reg <= 1'b1;
            else if (dec.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        proc_idx_reg <= mem_raddr;
        if (proc_hit && !hit_found_reg)
            hit_idx_reg <= proc_idx_reg;
        if (accept)
        begin
            sp_reg     <= port_idx;
            src_reg    <= evt.source_addr;
            dst_reg    <= evt.dest_addr;
            lookup_reg <= !is_broadcast(evt.dest_addr) && (evt.dest_addr != '0);
        end
        if (accept && !frame_go)
        begin
            res_mask_reg  <= '0;
            res_flood_reg <= 1'b0;
        end
        else if (finish_load)
        begin
            res_mask_reg  <= mask;
            res_flood_reg <= !hit_found_reg;
        end
    end

    assign dec.valid       = res_valid_reg;
    assign dec.egress_mask = res_mask_reg;
    assign dec.flooded     = res_flood_reg;

    // checks
    `LBF_ASSERT_IMPLY(a_no_same_entry, clk, rst_n, mem_we && mem_re, mem_waddr != mem_raddr, "memory read and write hit the same entry")
    `LBF_ASSERT_IMPLY(a_known_single, clk, rst_n, dec.valid && !dec.flooded, $onehot0(dec.egress_mask), "known destination sent to more than one port")
    `LBF_ASSERT_NEXT(a_sweep_ends, clk, rst_n, (state_reg == ST_SWEEP) && proc_valid_reg && (proc_idx_reg == LAST_IDX), state_reg == ST_FINISH, "sweep did not end after the last entry")

endmodule

`default_nettype wire

// File: rtl/core/lbf_addr_mem.sv
// Learned station address memory: one write port, one registered read port.
`default_nettype none

module lbf_addr_mem #(
    parameter  int NUM_PORTS = lbf_pkg::DEFAULT_NUM_PORTS,
    localparam int IDX_W     = $clog2(NUM_PORTS)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      we,
    input  wire logic [IDX_W-1:0]          waddr,
    input  wire logic [lbf_pkg::ADDR_W-1:0] wdata,
    input  wire logic                      re,
    input  wire logic [IDX_W-1:0]          raddr,
    output logic      [lbf_pkg::ADDR_W-1:0] rdata
);
    import lbf_pkg::*;

    logic [ADDR_W-1:0]    addr_mem [NUM_PORTS];
    logic [NUM_PORTS-1:0] written_reg;
    logic [ADDR_W-1:0]    rd_raw_reg;
    logic                 rd_written_reg;

    // storage array, no reset
    always_ff @(posedge clk)
    begin
        if (we)
            addr_mem[waddr] <= wdata;
        if (re)
            rd_raw_reg <= addr_mem[raddr];
    end

    // written flags: an entry never written reads as unlearned
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (we)
                written_reg[waddr] <= 1'b1;
            if (re)
                rd_written_reg <= written_reg[raddr];
        end
    end

    assign rdata = rd_written_reg ? rd_raw_reg : '0;

endmodule

`default_nettype wire

// File: rtl/core/lbf_mask_gen.sv
// Egress mask: single hit port, or every connected port but the source.
`default_nettype none

module lbf_mask_gen #(
    parameter  int NUM_PORTS = lbf_pkg::DEFAULT_NUM_PORTS,
    localparam int IDX_W     = $clog2(NUM_PORTS)
) (
    input  wire logic [NUM_PORTS-1:0]       connected,
    input  wire logic [IDX_W-1:0]           src_port,
    input  wire logic                       hit_found,
    input  wire logic [IDX_W-1:0]           hit_port,
    output logic      [lbf_pkg::MASK_W-1:0] egress_mask
);
    import lbf_pkg::*;

    // ports above the mask width are not shown
    for (genvar i = 0; i < MASK_W; i++)
    begin : g_bit
        if (i < NUM_PORTS)
        begin : g_live
            assign egress_mask[i] = (IDX_W'(i) != src_port) &&
                                    (hit_found ? (hit_port == IDX_W'(i)) : connected[i]);
        end
        else
        begin : g_none
            assign egress_mask[i] = 1'b0;
        end
    end

endmodule

`default_nettype wire
